// ----- hw/rtl/priority_event_scheduler_assert.svh -----
// Assertion macros for the priority event scheduler.
// Needs nothing else; define NO_ASSERTIONS to compile them out.
`ifndef PRIORITY_EVENT_SCHEDULER_ASSERT_SVH
`define PRIORITY_EVENT_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define PES_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define PES_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PES_ASSERT(label, clk, rst_n, prop, msg)
`define PES_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/pes_pkg.sv -----
// Shared types and codes for the priority event scheduler.
// No dependencies; used by the channel interfaces and the top level.
package pes_pkg;

    // Operation codes carried by a request beat
    typedef enum logic [1:0] {
        OP_SEND     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_QUEUE = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_QUEUE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_PRIORITY_MAP = 2'd1;
    localparam logic [1:0] CFG_ATOMIC_MASK  = 2'd2;

    // Field widths
    localparam int EVENT_W   = 32;
    localparam int QID_W     = 3;
    localparam int QCOUNT_W  = 4;
    localparam int PRIO_W    = 4;
    localparam int PMAP_W    = 32;
    localparam int AMASK_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 32;

    // Queues with a priority and atomic bit in the registers
    localparam int MAPPED_QUEUES = 8;

    // Reset value of the queue-count configuration register
    localparam logic [QCOUNT_W-1:0] QUEUE_COUNT_RST = 4'd8;

endpackage

// ----- hw/rtl/pes_channels.sv -----
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on pes_pkg for the operation and status types.
interface pes_req_if;
    logic                          valid;
    logic                          ready;
    pes_pkg::op_t                  operation;
    logic [pes_pkg::EVENT_W-1:0]   event_id;
    logic [pes_pkg::QID_W-1:0]     queue_id;

    modport source (output valid, output operation, output event_id, output queue_id,
                    input ready);
    modport sink   (input valid, input operation, input event_id, input queue_id,
                    output ready);
endinterface

interface pes_rsp_if;
    logic                          valid;
    logic                          ready;
    pes_pkg::status_t              status;
    logic                          event_valid;
    logic [pes_pkg::EVENT_W-1:0]   out_event_id;
    logic [pes_pkg::QID_W-1:0]     out_queue_id;

    modport source (output valid, output status, output event_valid, output out_event_id,
                    output out_queue_id, input ready);
    modport sink   (input valid, input status, input event_valid, input out_event_id,
                    input out_queue_id, output ready);
endinterface

// ----- hw/rtl/priority_event_scheduler.sv -----
// Two register stages: the request register, then the result register with the store read.
// Throughput: one request per cycle while the result channel is not stalled; the single-port
// event store takes one send write or one dispatch read per cycle. Reset: all queues empty
// and open, queue_count 8, priority map and atomic mask zero; the event store is not
// cleared and no clearing pass runs.
// Depends on pes_pkg, pes_channels and priority_event_scheduler_assert.svh.
`include "priority_event_scheduler_assert.svh"

module priority_event_scheduler #(
    parameter int NUM_QUEUES = 8,
    parameter int FIFO_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pes_pkg::CFG_DW-1:0]     cfg_wdata,
    pes_req_if.sink                        req,
    pes_rsp_if.source                      rsp
);

    localparam int PW     = $clog2(FIFO_DEPTH);
    localparam int CW     = $clog2(FIFO_DEPTH + 1);
    localparam int DEPTH  = NUM_QUEUES * FIFO_DEPTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW     = pes_pkg::QCOUNT_W + 1;
    localparam int LEVELS = 2 ** pes_pkg::PRIO_W;

    // Configuration registers
    logic [pes_pkg::QCOUNT_W-1:0] queue_count_reg;
    logic [pes_pkg::PMAP_W-1:0]   priority_map_reg;
    logic [pes_pkg::AMASK_W-1:0]  atomic_mask_reg;

    // Request stage
    logic                         a_valid_reg;
    pes_pkg::op_t                 a_op_reg;
    logic [pes_pkg::EVENT_W-1:0]  a_event_reg;
    logic [pes_pkg::QID_W-1:0]    a_qid_reg;

    // Result stage
    logic                         b_valid_reg;
    logic                         b_valid_next;
    pes_pkg::status_t             b_status_reg;
    logic                         b_event_valid_reg;
    logic [pes_pkg::QID_W-1:0]    b_qid_reg;
    logic [pes_pkg::EVENT_W-1:0]  mem_rd_reg;

    // Queue state
    logic [PW-1:0]                head_reg [NUM_QUEUES];
    logic [PW-1:0]                head_next [NUM_QUEUES];
    logic [PW-1:0]                tail_reg [NUM_QUEUES];
    logic [PW-1:0]                tail_next [NUM_QUEUES];
    logic [CW-1:0]                fill_reg [NUM_QUEUES];
    logic [CW-1:0]                fill_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]        blocked_reg;
    logic [NUM_QUEUES-1:0]        blocked_next;

    // Event store
    logic [pes_pkg::EVENT_W-1:0]  mem [DEPTH];
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_addr;

    // Datapath
    logic                         advance;
    logic [NW-1:0]                active_n;
    logic                         qid_ok;
    logic [NUM_QUEUES-1:0]        sel_oh;
    logic [NUM_QUEUES-1:0]        elig;
    logic [NUM_QUEUES-1:0]        win_oh;
    logic [pes_pkg::PRIO_W-1:0]   prio [NUM_QUEUES];
    logic [LEVELS-1:0]            level_hit;
    logic [pes_pkg::PRIO_W-1:0]   min_level;
    logic                         found;
    logic [pes_pkg::QID_W-1:0]    win_qid;
    logic [PW-1:0]                sel_tail;
    logic [CW-1:0]                sel_fill;
    logic [AW-1:0]                sel_base;
    logic [PW-1:0]                win_head;
    logic [AW-1:0]                win_base;
    logic                         win_atomic;
    pes_pkg::status_t             status_c;
    logic                         event_valid_c;

    // Move a beat from the request stage when the result register is free or draining
    assign advance      = a_valid_reg && (!b_valid_reg || rsp.ready);
    assign req.ready    = !a_valid_reg || advance;
    assign b_valid_next = advance || (b_valid_reg && !rsp.ready);

    // Drive the result channel
    assign rsp.valid        = b_valid_reg;
    assign rsp.status       = b_status_reg;
    assign rsp.event_valid  = b_event_valid_reg;
    assign rsp.out_event_id = b_event_valid_reg ? mem_rd_reg : '0;
    assign rsp.out_queue_id = b_qid_reg;

    // Queue selection, eligibility and per-queue fields
    always_comb
    begin
        logic [NW-1:0] qc_ext;
        logic [NW-1:0] nq;
        qc_ext   = NW'(queue_count_reg);
        nq       = NW'(NUM_QUEUES);
        active_n = (qc_ext < nq) ? qc_ext : nq;
        qid_ok   = NW'(a_qid_reg) < active_n;
        sel_tail = '0;
        sel_fill = '0;
        sel_base = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            sel_oh[q] = (NW'(q) == NW'(a_qid_reg));
            elig[q]   = (NW'(q) < active_n) && (fill_reg[q] != '0) && !blocked_reg[q];
            if (q < pes_pkg::MAPPED_QUEUES)
                prio[q] = pes_pkg::PRIO_W'(priority_map_reg >> (pes_pkg::PRIO_W * q));
            else
                prio[q] = '1;
            if (sel_oh[q])
            begin
                sel_tail = tail_reg[q];
                sel_fill = fill_reg[q];
                sel_base = AW'(q * FIFO_DEPTH);
            end
        end
    end

    // Find the lowest priority level held by an eligible queue
    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            level_hit[l] = 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++)
                if (elig[q] && (prio[q] == pes_pkg::PRIO_W'(l)))
                    level_hit[l] = 1'b1;
        end
        min_level = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
            if (level_hit[l])
                min_level = pes_pkg::PRIO_W'(l);
        found = |elig;
    end

    // Pick the lowest-numbered eligible queue at that level
    always_comb
    begin
        win_oh     = '0;
        win_qid    = '0;
        win_head   = '0;
        win_base   = '0;
        win_atomic = 1'b0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--)
        begin
            if (elig[q] && (prio[q] == min_level))
            begin
                win_oh   = '0;
                win_oh[q] = 1'b1;
                win_qid  = pes_pkg::QID_W'(q);
                win_head = head_reg[q];
                win_base = AW'(q * FIFO_DEPTH);
                if (q < pes_pkg::MAPPED_QUEUES)
                    win_atomic = 1'(atomic_mask_reg >> q);
                else
                    win_atomic = 1'b0;
            end
        end
    end

    // Work out the operation's effect on the queues and its result
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        blocked_next  = blocked_reg;
        status_c      = pes_pkg::ST_DONE;
        event_valid_c = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = sel_base + AW'(sel_tail);
        unique case (a_op_reg)
            pes_pkg::OP_SEND:
            begin
                if (!qid_ok)
                    status_c = pes_pkg::ST_BAD_QUEUE;
                else if (sel_fill >= CW'(FIFO_DEPTH))
                    status_c = pes_pkg::ST_FULL;
                else
                begin
                    mem_we = advance;
                    for (int q = 0; q < NUM_QUEUES; q++)
                    begin
                        if (sel_oh[q])
                        begin
                            tail_next[q] = (tail_reg[q] == PW'(FIFO_DEPTH - 1)) ?
                                           '0 : tail_reg[q] + 1'b1;
                            fill_next[q] = fill_reg[q] + 1'b1;
                        end
                    end
                end
            end
            pes_pkg::OP_DISPATCH:
            begin
                mem_addr = win_base + AW'(win_head);
                if (!found)
                    status_c = pes_pkg::ST_EMPTY;
                else
                begin
                    event_valid_c = 1'b1;
                    mem_re        = advance;
                    for (int q = 0; q < NUM_QUEUES; q++)
                    begin
                        if (win_oh[q])
                        begin
                            head_next[q] = (head_reg[q] == PW'(FIFO_DEPTH - 1)) ?
                                           '0 : head_reg[q] + 1'b1;
                            fill_next[q] = fill_reg[q] - 1'b1;
                            if (win_atomic)
                                blocked_next[q] = 1'b1;
                        end
                    end
                end
            end
            pes_pkg::OP_COMPLETE:
            begin
                if (!qid_ok)
                    status_c = pes_pkg::ST_BAD_QUEUE;
                else
                    blocked_next = blocked_reg & ~sel_oh;
            end
            default:
                status_c = pes_pkg::ST_BAD_QUEUE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_count_reg  <= pes_pkg::QUEUE_COUNT_RST;
            priority_map_reg <= '0;
            atomic_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pes_pkg::CFG_QUEUE_COUNT:
                    queue_count_reg <= cfg_wdata[pes_pkg::QCOUNT_W-1:0];
                pes_pkg::CFG_PRIORITY_MAP:
                    priority_map_reg <= cfg_wdata[pes_pkg::PMAP_W-1:0];
                pes_pkg::CFG_ATOMIC_MASK:
                    atomic_mask_reg <= cfg_wdata[pes_pkg::AMASK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Hold stage valids and queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            blocked_reg <= '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                fill_reg[q] <= '0;
            end
        end
        else
        begin
            if (req.ready)
                a_valid_reg <= req.valid;
            b_valid_reg <= b_valid_next;
            if (advance)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                fill_reg    <= fill_next;
                blocked_reg <= blocked_next;
            end
        end
    end

    // Capture the request beat and load the result beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            a_op_reg    <= req.operation;
            a_event_reg <= req.event_id;
            a_qid_reg   <= req.queue_id;
        end
        if (advance)
        begin
            b_status_reg      <= status_c;
            b_event_valid_reg <= event_valid_c;
            b_qid_reg         <= event_valid_c ? win_qid : '0;
        end
    end

    // Event store: one access a cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= a_event_reg;
        if (mem_re)
            mem_rd_reg <= mem[mem_addr];
    end

    `PES_ASSERT(a_dispatch_loads, clk, rst_n, advance && mem_re |=> b_valid_reg && b_event_valid_reg, "dispatch hit did not reach the result register")
    `PES_ASSERT(a_event_done, clk, rst_n, b_valid_reg && b_event_valid_reg |-> b_status_reg == pes_pkg::ST_DONE, "returned event with a failure status")
    `PES_ASSERT(a_blocked_hold, clk, rst_n, !advance |=> $stable(blocked_reg), "blocked flags changed without an operation")
    `PES_ASSERT(a_rd_hold, clk, rst_n, b_valid_reg && !rsp.ready |=> $stable(mem_rd_reg), "read data changed while the result beat waited")
    `PES_ASSERT_ALWAYS(a_one_access, clk, !(mem_we && mem_re), "store written and read in one cycle")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the priority event scheduler.
// Depends on pes_pkg, the pes_channels interfaces and the scheduler top level.
`timescale 1ns / 100ps

module tb_top;

    localparam int LANES = 8;
    localparam int SLOTS = 16;

    // One result beat as the scheduler returns it
    typedef struct packed {
        pes_pkg::status_t                 status;
        logic                             hit;
        logic [pes_pkg::EVENT_W-1:0]      event_id;
        logic [pes_pkg::QID_W-1:0]        queue_id;
    } sched_result_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    // One line of the directed table: a request beat (repeated reps times, event id
    // stepping by one) or a register write; typed rows carry their own expectation
    typedef struct packed {
        row_kind_t                        kind;
        pes_pkg::op_t                     op;
        logic [pes_pkg::CFG_IDX_W-1:0]    reg_idx;
        logic [31:0]                      data;
        logic [pes_pkg::QID_W-1:0]        qid;
        logic [4:0]                       reps;
        logic                             typed;
        sched_result_t                    want;
    } stim_row_t;

    localparam sched_result_t R_DONE  = '{pes_pkg::ST_DONE, 1'b0, 32'h0, 3'd0};
    localparam sched_result_t R_EMPTY = '{pes_pkg::ST_EMPTY, 1'b0, 32'h0, 3'd0};
    localparam sched_result_t R_FULL  = '{pes_pkg::ST_FULL, 1'b0, 32'h0, 3'd0};
    localparam sched_result_t R_BAD   = '{pes_pkg::ST_BAD_QUEUE, 1'b0, 32'h0, 3'd0};

    localparam int DIR_ROWS = 32;
    localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
        // nothing queued after reset, unknown operation, complete on an open queue
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_EMPTY},
        '{ROW_BEAT, pes_pkg::OP_RESERVED, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_BAD},
        '{ROW_BEAT, pes_pkg::OP_COMPLETE, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_DONE},
        // extreme event ids and queue numbers, returned in order
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'hFFFF_FFFF, 3'd0, 5'd1, 1'b1, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'hA5A5_A5A5, 3'd7, 5'd1, 1'b1, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1,
          '{pes_pkg::ST_DONE, 1'b1, 32'h0, 3'd0}},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1,
          '{pes_pkg::ST_DONE, 1'b1, 32'hFFFF_FFFF, 3'd0}},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1,
          '{pes_pkg::ST_DONE, 1'b1, 32'hA5A5_A5A5, 3'd7}},
        // fill queue 3, then overflow it
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h5A00_0000, 3'd3, 5'd16, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h1234_5678, 3'd3, 5'd1, 1'b1, R_FULL},
        // queues not in use
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'd2, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd2, 5'd1, 1'b1, R_BAD},
        '{ROW_BEAT, pes_pkg::OP_COMPLETE, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd7, 5'd1, 1'b1, R_BAD},
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'd8, 3'd0, 5'd0, 1'b0, R_DONE},
        // atomic queue blocks, stays blocked when the mask is cleared, then completes
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_ATOMIC_MASK,
          32'h08, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_EMPTY},
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_ATOMIC_MASK,
          32'h00, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_EMPTY},
        '{ROW_BEAT, pes_pkg::OP_COMPLETE, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd3, 5'd1, 1'b1, R_DONE},
        // priority beats queue number
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h0000_0055, 3'd5, 5'd1, 1'b0, R_DONE},
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_PRIORITY_MAP,
          32'hFF0F_FFFF, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b0, R_DONE},
        // no queue in use, then a count above the number of queues
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'd0, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_DISPATCH, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_EMPTY},
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h0, 3'd0, 5'd1, 1'b1, R_BAD},
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'd15, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_BEAT, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'h7777_7777, 3'd7, 5'd1, 1'b0, R_DONE},
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_PRIORITY_MAP,
          32'h0, 3'd0, 5'd0, 1'b0, R_DONE},
        '{ROW_REG, pes_pkg::OP_SEND, pes_pkg::CFG_QUEUE_COUNT,
          32'd8, 3'd0, 5'd0, 1'b0, R_DONE}
    };

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [pes_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [pes_pkg::CFG_DW-1:0]        cfg_wdata;

    pes_req_if req_ch ();
    pes_rsp_if rsp_ch ();

    priority_event_scheduler #(
        .NUM_QUEUES (LANES),
        .FIFO_DEPTH (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Scheduler model: event slots, pointers, fill levels, blocked flags, registers
    logic [pes_pkg::EVENT_W-1:0]   slot_mem [LANES][SLOTS];
    logic [3:0]                    head_ptr [LANES];
    logic [3:0]                    tail_ptr [LANES];
    logic [4:0]                    fill_cnt [LANES];
    bit                            held     [LANES];
    logic [pes_pkg::QCOUNT_W-1:0]  q_count;
    logic [pes_pkg::PMAP_W-1:0]    prio_map;
    logic [pes_pkg::AMASK_W-1:0]   atomic_map;

    sched_result_t  result_due_q [$];
    bit             cur_typed;
    sched_result_t  cur_want;
    int             err_cnt;
    int             tx_gap_pct;
    int             rx_stall_pct;
    int             hold_asks;

    function automatic int live_queues();
        return (q_count > LANES) ? LANES : int'(q_count);
    endfunction

    // Apply one request to the model and return the result it earns
    function automatic sched_result_t schedule_op(pes_pkg::op_t op,
                                                  logic [pes_pkg::EVENT_W-1:0] ev,
                                                  logic [pes_pkg::QID_W-1:0] qid);
        sched_result_t res;
        int            n;
        int            best;
        logic [3:0]    best_prio;
        bit            found;
        res       = R_DONE;
        n         = live_queues();
        best      = 0;
        best_prio = '0;
        found     = 1'b0;
        case (op)
            pes_pkg::OP_SEND:
            begin
                if (qid >= n)
                    res.status = pes_pkg::ST_BAD_QUEUE;
                else if (fill_cnt[qid] >= SLOTS)
                    res.status = pes_pkg::ST_FULL;
                else
                begin
                    // four-bit pointers wrap at the sixteen-slot depth
                    slot_mem[qid][tail_ptr[qid]] = ev;
                    tail_ptr[qid] = tail_ptr[qid] + 4'd1;
                    fill_cnt[qid] = fill_cnt[qid] + 5'd1;
                end
            end
            pes_pkg::OP_DISPATCH:
            begin
                // lowest priority value wins, lowest queue number breaks ties
                for (int q = 0; q < n; q++)
                begin
                    if (fill_cnt[q] != 0 && !held[q] &&
                        (!found || prio_map[4*q +: 4] < best_prio))
                    begin
                        found     = 1'b1;
                        best      = q;
                        best_prio = prio_map[4*q +: 4];
                    end
                end
                if (!found)
                    res.status = pes_pkg::ST_EMPTY;
                else
                begin
                    res.hit      = 1'b1;
                    res.event_id = slot_mem[best][head_ptr[best]];
                    res.queue_id = best[pes_pkg::QID_W-1:0];
                    head_ptr[best] = head_ptr[best] + 4'd1;
                    fill_cnt[best] = fill_cnt[best] - 5'd1;
                    if (atomic_map[best])
                        held[best] = 1'b1;
                end
            end
            pes_pkg::OP_COMPLETE:
            begin
                if (qid >= n)
                    res.status = pes_pkg::ST_BAD_QUEUE;
                else
                    held[qid] = 1'b0;
            end
            default:
                res.status = pes_pkg::ST_BAD_QUEUE;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t ns, %s: got %h, want %h", $time, field, got, want);
        err_cnt++;
    endtask

    // Offer one request beat and hold it until taken; entered and left at a falling edge
    task automatic drive_beat(input pes_pkg::op_t op, input logic [pes_pkg::EVENT_W-1:0] ev,
                              input logic [pes_pkg::QID_W-1:0] qid, input bit typed,
                              input sched_result_t want);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cur_typed = typed;
        cur_want  = want;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.event_id  <= ev;
        req_ch.queue_id  <= qid;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding result, then let the pipeline settle
    task automatic drain_results();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (result_due_q.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        if (result_due_q.size() != 0)
        begin
            flag_mismatch("results never returned", result_due_q.size(), 0);
            result_due_q.delete();
        end
        repeat (4) @(negedge clk);
    endtask

    // Write one register while idle and mirror it in the model
    task automatic write_reg(input logic [pes_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pes_pkg::CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pes_pkg::CFG_QUEUE_COUNT:  q_count    = val[pes_pkg::QCOUNT_W-1:0];
            pes_pkg::CFG_PRIORITY_MAP: prio_map   = val[pes_pkg::PMAP_W-1:0];
            pes_pkg::CFG_ATOMIC_MASK:  atomic_map = val[pes_pkg::AMASK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Random request, mostly aimed at queues in use; completes favour blocked queues
    task automatic random_beat();
        pes_pkg::op_t              op;
        logic [pes_pkg::QID_W-1:0] qid;
        int                        roll;
        int                        live;
        int                        blocked [$];
        roll = $urandom_range(99);
        live = live_queues();
        if (roll < 45)
            op = pes_pkg::OP_SEND;
        else if (roll < 83)
            op = pes_pkg::OP_DISPATCH;
        else if (roll < 97)
            op = pes_pkg::OP_COMPLETE;
        else
            op = pes_pkg::OP_RESERVED;
        if (live > 0 && $urandom_range(99) < 85)
            qid = pes_pkg::QID_W'($urandom_range(live - 1, 0));
        else
            qid = pes_pkg::QID_W'($urandom_range(LANES - 1, 0));
        if (op == pes_pkg::OP_COMPLETE && $urandom_range(99) < 70)
        begin
            for (int q = 0; q < live; q++)
                if (held[q])
                    blocked.insert(blocked.size(), q);
            if (blocked.size() != 0)
                qid = pes_pkg::QID_W'(blocked[$urandom_range(blocked.size() - 1, 0)]);
        end
        drive_beat(op, $urandom, qid, 1'b0, R_DONE);
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result sink: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Predict on every request beat, check every result beat against the oldest prediction
    always @(posedge clk)
    begin : watch
        sched_result_t got;
        sched_result_t want;
        sched_result_t pred;
        if (req_ch.valid && req_ch.ready)
        begin
            pred = schedule_op(req_ch.operation, req_ch.event_id, req_ch.queue_id);
            result_due_q.insert(result_due_q.size(), cur_typed ? cur_want : pred);
        end
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.status, rsp_ch.event_valid, rsp_ch.out_event_id,
                    rsp_ch.out_queue_id};
            if (result_due_q.size() == 0)
                flag_mismatch("result beat with nothing outstanding", got.event_id, 0);
            else
            begin
                want = result_due_q.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.hit !== want.hit)
                    flag_mismatch("event_valid", 32'(got.hit), 32'(want.hit));
                if (got.event_id !== want.event_id)
                    flag_mismatch("out_event_id", got.event_id, want.event_id);
                if (got.queue_id !== want.queue_id)
                    flag_mismatch("out_queue_id", 32'(got.queue_id), 32'(want.queue_id));
            end
        end
    end

    // Stimulus: directed table, then random phases over several settings and idling modes
    initial
    begin
        stim_row_t row;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = pes_pkg::OP_SEND;
        req_ch.event_id  = '0;
        req_ch.queue_id  = '0;
        cur_typed        = 1'b0;
        cur_want         = R_DONE;
        err_cnt          = 0;
        tx_gap_pct       = 0;
        rx_stall_pct     = 0;
        hold_asks        = 0;
        q_count          = pes_pkg::QUEUE_COUNT_RST;
        prio_map         = '0;
        atomic_map       = '0;
        for (int q = 0; q < LANES; q++)
        begin
            head_ptr[q] = '0;
            tail_ptr[q] = '0;
            fill_cnt[q] = '0;
            held[q]     = 1'b0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TBL[i];
            if (row.kind == ROW_REG)
            begin
                drain_results();
                write_reg(row.reg_idx, row.data);
            end
            else
                for (int r = 0; r < row.reps; r++)
                    drive_beat(row.op, row.data + r, row.qid, row.typed, row.want);
        end

        // random phases: idling mode cycles none, sender, receiver, both
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    write_reg(pes_pkg::CFG_QUEUE_COUNT, 8);
                    write_reg(pes_pkg::CFG_PRIORITY_MAP, 32'h0);
                    write_reg(pes_pkg::CFG_ATOMIC_MASK, 32'h00);
                end
                1:
                begin
                    write_reg(pes_pkg::CFG_QUEUE_COUNT, 1);
                    write_reg(pes_pkg::CFG_PRIORITY_MAP, 32'hFFFF_FFFF);
                    write_reg(pes_pkg::CFG_ATOMIC_MASK, 32'hFF);
                end
                3:
                begin
                    write_reg(pes_pkg::CFG_QUEUE_COUNT, $urandom_range(15, 9));
                    write_reg(pes_pkg::CFG_PRIORITY_MAP, $urandom);
                    write_reg(pes_pkg::CFG_ATOMIC_MASK, 32'hFF);
                end
                default:
                begin
                    write_reg(pes_pkg::CFG_QUEUE_COUNT, $urandom_range(8, 1));
                    write_reg(pes_pkg::CFG_PRIORITY_MAP, $urandom);
                    write_reg(pes_pkg::CFG_ATOMIC_MASK, $urandom_range(255, 0));
                end
            endcase
            case (ph % 4)
                0:       begin tx_gap_pct = 0;  rx_stall_pct <= 0;  end
                1:       begin tx_gap_pct = 45; rx_stall_pct <= 0;  end
                2:       begin tx_gap_pct = 0;  rx_stall_pct <= 45; end
                default: begin tx_gap_pct = 32; rx_stall_pct <= 32; end
            endcase
            for (int k = 0; k < 125; k++)
            begin
                // back the block up behind a stalled receiver
                if (ph == 4 && k == 40)
                    hold_asks <= hold_asks + 1;
                // pause the sender until every result is back
                if (ph == 5 && k == 60)
                    drain_results();
                random_beat();
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pes_pkg.sv
hw/rtl/pes_channels.sv
hw/rtl/priority_event_scheduler.sv
tb/tb_top.sv
